/* sv/etok_pkg.sv */
`timescale 1ns / 1ps

package etok_pkg;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_mark;
  } char_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [2:0]  relation;
    logic        is_value_char;
    logic [7:0]  value_char;
    logic [1:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_RESULTS-1:0] item;
    logic [2:0]             count;
  } batch_t;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_HELD  = 4'b0010,
    MODE_NUM   = 4'b0100,
    MODE_IDENT = 4'b1000
  } mode_t;

  localparam logic [3:0] KIND_END    = 4'd0;
  localparam logic [3:0] KIND_PLUS   = 4'd1;
  localparam logic [3:0] KIND_MINUS  = 4'd2;
  localparam logic [3:0] KIND_TIMES  = 4'd3;
  localparam logic [3:0] KIND_DIVIDE = 4'd4;
  localparam logic [3:0] KIND_ROLL   = 4'd5;
  localparam logic [3:0] KIND_LPAREN = 4'd6;
  localparam logic [3:0] KIND_RPAREN = 4'd7;
  localparam logic [3:0] KIND_LBRACK = 4'd8;
  localparam logic [3:0] KIND_RBRACK = 4'd9;
  localparam logic [3:0] KIND_COMMA  = 4'd10;
  localparam logic [3:0] KIND_RELOP  = 4'd11;
  localparam logic [3:0] KIND_NUMBER = 4'd12;
  localparam logic [3:0] KIND_IDENT  = 4'd13;
  localparam logic [3:0] KIND_IN     = 4'd14;
  localparam logic [3:0] KIND_ERROR  = 4'd15;

  localparam logic [2:0] REL_LT = 3'd0;
  localparam logic [2:0] REL_GT = 3'd1;
  localparam logic [2:0] REL_LE = 3'd2;
  localparam logic [2:0] REL_GE = 3'd3;
  localparam logic [2:0] REL_NE = 3'd4;
  localparam logic [2:0] REL_EQ = 3'd5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNEXPECT = 2'd1;
  localparam logic [1:0] ERR_FRACTION = 2'd2;

  localparam logic [1:0] KW_NONE    = 2'd0;
  localparam logic [1:0] KW_I       = 2'd1;
  localparam logic [1:0] KW_IN      = 2'd2;
  localparam logic [1:0] KW_NOMATCH = 2'd3;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LOW_D  = 8'h64;
  localparam logic [7:0] CH_UP_D   = 8'h44;
  localparam logic [7:0] CH_LOW_I  = 8'h69;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, [8'h09:8'h0D]};
  endfunction

endpackage

/* sv/etok_core.sv */
`timescale 1ns / 1ps

module etok_core import etok_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  char_t  char_data,
  output batch_t batch
);

  mode_t                    mode, mode_next;
  logic [7:0]               held, held_next;
  logic                     dot, dot_next;
  logic [1:0]               kw, kw_next;
  logic [POSITION_BITS-1:0] line, line_next;
  logic [POSITION_BITS-1:0] col, col_next;

  logic [POSITION_BITS-1:0] line_after, col_after;
  logic [31:0]              line_wide, col_wide, line_wide_a, col_wide_a;
  logic [15:0]              ln_b, cl_b, ln_a, cl_a;
  logic [7:0]               c;
  logic                     is_dd, absorbed, num_ch, id_ch;
  logic [2:0]               n;
  tok_t [MAX_RESULTS-1:0]   res;
  logic [2:0]               held_rel;

  function automatic tok_t mk(input logic [3:0] kind, input logic [2:0] rel,
                              input logic isv, input logic [7:0] ch,
                              input logic [1:0] err, input logic [15:0] ln,
                              input logic [15:0] cl);
    tok_t t;
    t.token_kind    = kind;
    t.relation      = rel;
    t.is_value_char = isv;
    t.value_char    = ch;
    t.error_code    = err;
    t.line_number   = ln;
    t.column_number = cl;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  always_comb begin
    c = char_data.byte_in;
    if (c == CH_LF) begin
      line_after = (line == '1) ? line : line + POSITION_BITS'(1);
      col_after  = '0;
    end else begin
      line_after = line;
      col_after  = (col == '1) ? col : col + POSITION_BITS'(1);
    end
    line_wide   = 32'(line);
    col_wide    = 32'(col);
    line_wide_a = 32'(line_after);
    col_wide_a  = 32'(col_after);
    ln_b = (line_wide > 32'h0000_FFFF) ? 16'hFFFF : line_wide[15:0];
    cl_b = (col_wide > 32'h0000_FFFF) ? 16'hFFFF : col_wide[15:0];
    ln_a = (line_wide_a > 32'h0000_FFFF) ? 16'hFFFF : line_wide_a[15:0];
    cl_a = (col_wide_a > 32'h0000_FFFF) ? 16'hFFFF : col_wide_a[15:0];
  end

  always_comb begin
    is_dd  = (held == CH_LOW_D) || (held == CH_UP_D);
    num_ch = is_digit(c) || (c == CH_DOT);
    id_ch  = is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    case (held)
      CH_LT:   held_rel = REL_LE;
      CH_GT:   held_rel = REL_GE;
      CH_BANG: held_rel = REL_NE;
      default: held_rel = REL_EQ;
    endcase
    absorbed = !char_data.end_mark &&
               (((mode == MODE_HELD) && is_dd && is_alpha(c)) ||
                ((mode == MODE_HELD) && !is_dd && (c == CH_EQ)) ||
                ((mode == MODE_NUM) && num_ch) ||
                ((mode == MODE_IDENT) && id_ch));
  end

  always_comb begin
    res       = '0;
    n         = 3'd0;
    mode_next = mode;
    held_next = held;
    dot_next  = dot;
    kw_next   = kw;
    line_next = char_data.end_mark ? line : line_after;
    col_next  = char_data.end_mark ? col : col_after;
    if (absorbed) begin
      case (mode)
        MODE_HELD: begin
          if (is_dd) begin
            res[0]    = mk(KIND_IDENT, REL_LT, 1'b1, held, ERR_NONE, ln_b, cl_b);
            res[1]    = mk(KIND_IDENT, REL_LT, 1'b1, c, ERR_NONE, ln_a, cl_a);
            n         = 3'd2;
            mode_next = MODE_IDENT;
            kw_next   = KW_NOMATCH;
          end else begin
            res[0]    = mk(KIND_RELOP, held_rel, 1'b0, 8'd0, ERR_NONE, ln_a, cl_a);
            n         = 3'd1;
            mode_next = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          res[0]   = mk(KIND_NUMBER, REL_LT, 1'b1, c, ERR_NONE, ln_a, cl_a);
          n        = 3'd1;
          dot_next = (c == CH_DOT);
        end
        default: begin
          res[0]  = mk(KIND_IDENT, REL_LT, 1'b1, c, ERR_NONE, ln_a, cl_a);
          n       = 3'd1;
          kw_next = ((kw == KW_I) && (c == CH_LOW_N)) ? KW_IN : KW_NOMATCH;
        end
      endcase
    end else begin
      case (mode)
        MODE_HELD: begin
          if (is_dd) begin
            res[0] = mk(KIND_ROLL, REL_LT, 1'b0, 8'd0, ERR_NONE, ln_b, cl_b);
          end else if (held == CH_LT) begin
            res[0] = mk(KIND_RELOP, REL_LT, 1'b0, 8'd0, ERR_NONE, ln_b, cl_b);
          end else if (held == CH_GT) begin
            res[0] = mk(KIND_RELOP, REL_GT, 1'b0, 8'd0, ERR_NONE, ln_b, cl_b);
          end else begin
            res[0] = mk(KIND_ERROR, REL_LT, 1'b0, held, ERR_UNEXPECT, ln_b, cl_b);
          end
          n = 3'd1;
        end
        MODE_NUM: begin
          if (dot) begin
            res[0] = mk(KIND_ERROR, REL_LT, 1'b0, 8'd0, ERR_FRACTION, ln_b, cl_b);
            res[1] = mk(KIND_NUMBER, REL_LT, 1'b1, CH_ZERO, ERR_NONE, ln_b, cl_b);
            res[2] = mk(KIND_NUMBER, REL_LT, 1'b0, 8'd0, ERR_NONE, ln_b, cl_b);
            n      = 3'd3;
          end else begin
            res[0] = mk(KIND_NUMBER, REL_LT, 1'b0, 8'd0, ERR_NONE, ln_b, cl_b);
            n      = 3'd1;
          end
          dot_next = 1'b0;
        end
        MODE_IDENT: begin
          res[0]  = mk((kw == KW_IN) ? KIND_IN : KIND_IDENT, REL_LT, 1'b0, 8'd0,
                       ERR_NONE, ln_b, cl_b);
          n       = 3'd1;
          kw_next = KW_NONE;
        end
        default: begin
          n = 3'd0;
        end
      endcase
      mode_next = MODE_IDLE;
      if (char_data.end_mark) begin
        res[n[1:0]] = mk(KIND_END, REL_LT, 1'b0, 8'd0, ERR_NONE, ln_b, cl_b);
        n           = n + 3'd1;
      end else if (!is_space(c)) begin
        case (c)
          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN,
          CH_LBRACK, CH_RBRACK, CH_COMMA: begin
            case (c)
              CH_PLUS:   res[n[1:0]] = mk(KIND_PLUS, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
              CH_MINUS:  res[n[1:0]] = mk(KIND_MINUS, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
              CH_STAR:   res[n[1:0]] = mk(KIND_TIMES, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
              CH_SLASH:  res[n[1:0]] = mk(KIND_DIVIDE, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
              CH_LPAREN: res[n[1:0]] = mk(KIND_LPAREN, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
              CH_RPAREN: res[n[1:0]] = mk(KIND_RPAREN, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
              CH_LBRACK: res[n[1:0]] = mk(KIND_LBRACK, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
              CH_RBRACK: res[n[1:0]] = mk(KIND_RBRACK, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
              default:   res[n[1:0]] = mk(KIND_COMMA, REL_LT, 1'b0, 8'd0, ERR_NONE,
                                          ln_a, cl_a);
            endcase
            n = n + 3'd1;
          end
          CH_LOW_D, CH_UP_D, CH_LT, CH_GT, CH_BANG, CH_EQ: begin
            held_next = c;
            mode_next = MODE_HELD;
          end
          default: begin
            if (is_digit(c)) begin
              res[n[1:0]] = mk(KIND_NUMBER, REL_LT, 1'b1, c, ERR_NONE, ln_a, cl_a);
              mode_next   = MODE_NUM;
              dot_next    = 1'b0;
            end else if (is_alpha(c)) begin
              res[n[1:0]] = mk(KIND_IDENT, REL_LT, 1'b1, c, ERR_NONE, ln_a, cl_a);
              mode_next   = MODE_IDENT;
              kw_next     = (c == CH_LOW_I) ? KW_I : KW_NOMATCH;
            end else begin
              res[n[1:0]] = mk(KIND_ERROR, REL_LT, 1'b0, c, ERR_UNEXPECT, ln_a, cl_a);
            end
            n = n + 3'd1;
          end
        endcase
      end
    end
    batch.item  = res;
    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      held <= 8'd0;
      dot  <= 1'b0;
      kw   <= KW_NONE;
      line <= POSITION_BITS'(1);
      col  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      held <= held_next;
      dot  <= dot_next;
      kw   <= kw_next;
      line <= line_next;
      col  <= col_next;
    end
  end

endmodule

/* sv/etok_outq.sv */
`timescale 1ns / 1ps

module etok_outq import etok_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  batch_t batch,
  output logic   free,
  output logic   tok_valid,
  input  logic   tok_ready,
  output tok_t   tok_data
);

  localparam int IDX_W = $clog2(MAX_RESULTS);

  tok_t [MAX_RESULTS-1:0] slot;
  logic [2:0]             count;
  logic [IDX_W-1:0]       idx;
  logic                   last;

  always_comb begin
    last      = (3'({1'b0, idx}) + 3'd1 == count);
    tok_valid = (count != 3'd0);
    free      = (count == 3'd0) || (tok_ready && last);
    tok_data  = slot[idx];
    tok_data.last_of_run = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
      idx   <= '0;
    end else if (load) begin
      count <= batch.count;
      idx   <= '0;
    end else if (tok_valid && tok_ready) begin
      if (last) begin
        count <= 3'd0;
        idx   <= '0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= batch.item;
    end
  end

endmodule

/* sv/expression_tokenizer_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// char      char_valid/char_ready    char_data (char_t: byte_in, end_mark)
// tok       tok_valid/tok_ready      tok_data (tok_t: token kind, value, position)
//
// A character transaction is decoded in the cycle it is accepted and its results
// are written into a four-entry result register; they leave one per cycle while
// tok_ready is high. With tok_ready high, one character per cycle is taken while each
// causes at most one result; a character with k results holds the input until the last is taken.
// Reset clears the scan state, sets the line count to one and the column to zero.
// A stalled tok_ready holds char_ready low while the result register holds any result.

module expression_tokenizer_top import etok_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  char_valid,
  output logic  char_ready,
  input  char_t char_data,
  output logic  tok_valid,
  input  logic  tok_ready,
  output tok_t  tok_data
);

  batch_t batch;
  logic   accept;
  logic   free;

  assign char_ready = free;
  assign accept     = char_valid && free;

  etok_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .char_data(char_data),
    .batch    (batch)
  );

  etok_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .batch    (batch),
    .free     (free),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok_data (tok_data)
  );

endmodule

/* verif/tb_expression_tokenizer_top.sv */
`timescale 1ns / 1ps

module tb_expression_tokenizer_top;
  import etok_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam logic [2:0] REL_NONE = 3'd0;

  logic  clk;
  logic  rst;
  logic  char_valid;
  logic  char_ready;
  char_t char_data;
  logic  tok_valid;
  logic  tok_ready;
  tok_t  tok_data;

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int quiet_cycles;
  bit hold_off_req;
  string relops[8] = '{"<", ">", "<=", ">=", "!=", "==", "!", "="};

  class lexer_checker;
    tok_t       expected_toks[$];
    tok_t       run_toks[$];
    int         failures;
    mode_t      mode;
    logic [7:0] held_byte;
    logic       dot_tail;
    logic [1:0] kw_state;
    logic [15:0] line_cnt;
    logic [15:0] col_cnt;

    function new();
      mode = MODE_IDLE;
      held_byte = 8'h00;
      dot_tail = 1'b0;
      kw_state = KW_NONE;
      line_cnt = 16'd1;
      col_cnt = 16'd0;
      failures = 0;
    endfunction

    function int outstanding();
      return expected_toks.size();
    endfunction

    function bit digit_byte(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function bit letter_byte(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function bit blank_byte(logic [7:0] c);
      return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function void add_token(logic [3:0] kind, logic [2:0] rel, logic isv,
                            logic [7:0] ch, logic [1:0] err);
      tok_t t;
      t.token_kind = kind;
      t.relation = rel;
      t.is_value_char = isv;
      t.value_char = ch;
      t.error_code = err;
      t.line_number = line_cnt;
      t.column_number = col_cnt;
      t.last_of_run = 1'b0;
      run_toks.push_back(t);
    endfunction

    function void add_plain(logic [3:0] kind);
      add_token(kind, REL_NONE, 1'b0, 8'h00, ERR_NONE);
    endfunction

    function void advance(logic [7:0] c);
      if (c == CH_LF) begin
        if (line_cnt != 16'hFFFF) line_cnt++;
        col_cnt = 16'd0;
      end else if (col_cnt != 16'hFFFF) begin
        col_cnt++;
      end
    endfunction

    function void close_held();
      if (held_byte == CH_LOW_D || held_byte == CH_UP_D) begin
        add_plain(KIND_ROLL);
      end else if (held_byte == CH_LT) begin
        add_token(KIND_RELOP, REL_LT, 1'b0, 8'h00, ERR_NONE);
      end else if (held_byte == CH_GT) begin
        add_token(KIND_RELOP, REL_GT, 1'b0, 8'h00, ERR_NONE);
      end else begin
        add_token(KIND_ERROR, REL_NONE, 1'b0, held_byte, ERR_UNEXPECT);
      end
      mode = MODE_IDLE;
    endfunction

    function void close_number();
      if (dot_tail) begin
        add_token(KIND_ERROR, REL_NONE, 1'b0, 8'h00, ERR_FRACTION);
        add_token(KIND_NUMBER, REL_NONE, 1'b1, CH_ZERO, ERR_NONE);
      end
      add_plain(KIND_NUMBER);
      dot_tail = 1'b0;
      mode = MODE_IDLE;
    endfunction

    function void close_ident();
      add_plain(kw_state == KW_IN ? KIND_IN : KIND_IDENT);
      kw_state = KW_NONE;
      mode = MODE_IDLE;
    endfunction

    function bit absorb(logic [7:0] c);
      logic [2:0] rel;
      if (mode == MODE_HELD) begin
        if (held_byte == CH_LOW_D || held_byte == CH_UP_D) begin
          if (letter_byte(c)) begin
            add_token(KIND_IDENT, REL_NONE, 1'b1, held_byte, ERR_NONE);
            mode = MODE_IDENT;
            kw_state = KW_NOMATCH;
          end else begin
            close_held();
          end
        end else if (c == CH_EQ) begin
          rel = held_byte == CH_LT ? REL_LE : held_byte == CH_GT ? REL_GE :
                held_byte == CH_BANG ? REL_NE : REL_EQ;
          advance(c);
          add_token(KIND_RELOP, rel, 1'b0, 8'h00, ERR_NONE);
          mode = MODE_IDLE;
          return 1'b1;
        end else begin
          close_held();
        end
      end
      if (mode == MODE_NUM) begin
        if (digit_byte(c) || c == CH_DOT) begin
          advance(c);
          dot_tail = (c == CH_DOT);
          add_token(KIND_NUMBER, REL_NONE, 1'b1, c, ERR_NONE);
          return 1'b1;
        end
        close_number();
      end else if (mode == MODE_IDENT) begin
        if (letter_byte(c) || digit_byte(c) || c == CH_UNDER) begin
          advance(c);
          kw_state = (kw_state == KW_I && c == CH_LOW_N) ? KW_IN : KW_NOMATCH;
          add_token(KIND_IDENT, REL_NONE, 1'b1, c, ERR_NONE);
          return 1'b1;
        end
        close_ident();
      end
      return 1'b0;
    endfunction

    function void start_token(logic [7:0] c);
      advance(c);
      if (blank_byte(c)) return;
      case (c)
        CH_PLUS:   add_plain(KIND_PLUS);
        CH_MINUS:  add_plain(KIND_MINUS);
        CH_STAR:   add_plain(KIND_TIMES);
        CH_SLASH:  add_plain(KIND_DIVIDE);
        CH_LPAREN: add_plain(KIND_LPAREN);
        CH_RPAREN: add_plain(KIND_RPAREN);
        CH_LBRACK: add_plain(KIND_LBRACK);
        CH_RBRACK: add_plain(KIND_RBRACK);
        CH_COMMA:  add_plain(KIND_COMMA);
        CH_LOW_D, CH_UP_D, CH_LT, CH_GT, CH_BANG, CH_EQ: begin
          held_byte = c;
          mode = MODE_HELD;
        end
        default: begin
          if (digit_byte(c)) begin
            mode = MODE_NUM;
            dot_tail = 1'b0;
            add_token(KIND_NUMBER, REL_NONE, 1'b1, c, ERR_NONE);
          end else if (letter_byte(c)) begin
            mode = MODE_IDENT;
            kw_state = (c == CH_LOW_I) ? KW_I : KW_NOMATCH;
            add_token(KIND_IDENT, REL_NONE, 1'b1, c, ERR_NONE);
          end else begin
            add_token(KIND_ERROR, REL_NONE, 1'b0, c, ERR_UNEXPECT);
          end
        end
      endcase
    endfunction

    function void take_char(char_t c);
      tok_t t;
      run_toks.delete();
      if (c.end_mark) begin
        case (mode)
          MODE_HELD:  close_held();
          MODE_NUM:   close_number();
          MODE_IDENT: close_ident();
          default: ;
        endcase
        mode = MODE_IDLE;
        add_plain(KIND_END);
      end else if (!absorb(c.byte_in)) begin
        start_token(c.byte_in);
      end
      if (run_toks.size() > 0) begin
        t = run_toks.pop_back();
        t.last_of_run = 1'b1;
        run_toks.push_back(t);
      end
      foreach (run_toks[i]) expected_toks.push_back(run_toks[i]);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (expected_toks.size() == 0) begin
        $error("token transaction with none expected: kind %0d", got.token_kind);
        failures++;
        return;
      end
      want = expected_toks.pop_front();
      compare("token_kind", 16'(want.token_kind), 16'(got.token_kind));
      compare("relation", 16'(want.relation), 16'(got.relation));
      compare("is_value_char", 16'(want.is_value_char), 16'(got.is_value_char));
      compare("value_char", 16'(want.value_char), 16'(got.value_char));
      compare("error_code", 16'(want.error_code), 16'(got.error_code));
      compare("line_number", want.line_number, got.line_number);
      compare("column_number", want.column_number, got.column_number);
      compare("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
    endfunction
  endclass

  lexer_checker sb;

  expression_tokenizer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data),
    .tok_valid  (tok_valid),
    .tok_ready  (tok_ready),
    .tok_data   (tok_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    tok_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        tok_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        tok_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && char_ready) sb.take_char(char_data);
      if (tok_valid && tok_ready) sb.check_token(tok_data);
      if ((char_valid && char_ready) || (tok_valid && tok_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  task automatic send_item(input char_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_data <= c;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    char_t c;
    c.byte_in = b;
    c.end_mark = 1'b0;
    send_item(c);
  endtask

  task automatic send_end();
    char_t c;
    c.byte_in = 8'($urandom_range(255));
    c.end_mark = 1'b1;
    send_item(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] any_letter();
    return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25)) :
                               8'(8'h41 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'(CH_ZERO + $urandom_range(9));
  endfunction

  function automatic logic [7:0] word_char();
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  task automatic send_random_token();
    string ops;
    int n;
    ops = "+-*/()[],";
    case ($urandom_range(19))
      0, 1, 2, 3: begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(any_digit());
        case ($urandom_range(3))
          0: begin
            send_byte(CH_DOT);
            n = $urandom_range(1, 2);
            repeat (n) send_byte(any_digit());
          end
          1: send_byte(CH_DOT);
          2: send_text("..");
          default: ;
        endcase
      end
      4, 5, 6, 7: begin
        case ($urandom_range(6))
          0: send_text("in");
          1: send_text("i");
          2: send_text("In");
          3: send_text("inx");
          4: begin
            send_byte($urandom_range(1) ? CH_LOW_D : CH_UP_D);
            send_byte(any_letter());
          end
          default: begin
            send_byte(any_letter());
            n = $urandom_range(4);
            repeat (n) send_byte(word_char());
          end
        endcase
      end
      8, 9: send_byte(ops[$urandom_range(ops.len() - 1)]);
      10, 11: send_text(relops[$urandom_range(7)]);
      12: begin
        send_byte($urandom_range(1) ? CH_LOW_D : CH_UP_D);
        send_byte($urandom_range(1) ? any_digit() : CH_LPAREN);
      end
      13, 14, 15: send_byte($urandom_range(1) ? CH_SPACE : 8'(8'h09 + $urandom_range(4)));
      16: send_byte(8'($urandom_range(255)));
      17: send_end();
      default: send_byte(CH_SPACE);
    endcase
  endtask

  task automatic random_phase(input int count);
    int first;
    first = items_sent;
    while (items_sent - first < count) send_random_token();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    char_valid = 1'b0;
    char_data = '0;
    hold_off_req = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    send_idle_pct = 22;
    recv_idle_pct = 84;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text("in+-*/()[],<=>7.");
    send_end();
    send_text("d!==\n");
    send_byte(8'hFF);
    send_text("Dx");
    send_byte(8'h00);
    send_end();

    random_phase(PHASE_ITEMS);
    send_idle_pct = 84;
    recv_idle_pct = 22;
    random_phase(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    random_phase(PHASE_ITEMS);

    @(negedge clk);
    char_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
